@@ design/tsp_pkg.sv @@
// Shared types and constants of the tensor shard partitioner.
`default_nettype none

package tsp_pkg;

    localparam int DIM_W    = 24;
    localparam int N_W      = 7;
    localparam int IDX_W    = 6;
    localparam int NR_W     = 4;
    localparam int BYTES_W  = 50;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ROWS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLS = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SHARD_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE  = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_SETUP,
        ST_DIV_ROW,
        ST_DIV_NC,
        ST_DIV_COL,
        ST_CALC,
        ST_LOAD
    } tsp_state_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] dividend;
        logic [N_W-1:0]   divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quotient;
        logic [N_W-1:0]   remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ design/tsp_if.sv @@
// Channel interfaces: matrix shape requests, shard results, register writes.
`default_nettype none

interface tsp_req_if;
    logic                      valid;
    logic                      ready;
    logic [tsp_pkg::DIM_W-1:0] row_count;
    logic [tsp_pkg::DIM_W-1:0] col_count;

    modport source (output valid, output row_count, output col_count, input ready);
    modport sink   (input valid, input row_count, input col_count, output ready);
endinterface

interface tsp_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tsp_pkg::STATUS_W-1:0] status;
    logic [tsp_pkg::IDX_W-1:0]    shard_index;
    logic [tsp_pkg::DIM_W-1:0]    row_start;
    logic [tsp_pkg::DIM_W-1:0]    row_end;
    logic [tsp_pkg::DIM_W-1:0]    col_start;
    logic [tsp_pkg::DIM_W-1:0]    col_end;
    logic [tsp_pkg::BYTES_W-1:0]  byte_size;
    logic                         last_shard;

    modport source (output valid, output status, output shard_index, output row_start,
                    output row_end, output col_start, output col_end, output byte_size,
                    output last_shard, input ready);
    modport sink   (input valid, input status, input shard_index, input row_start,
                    input row_end, input col_start, input col_end, input byte_size,
                    input last_shard, output ready);
endinterface

interface tsp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tsp_pkg::CFG_IDX_W-1:0]  index;
    logic [tsp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/tsp_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all band splits.
`default_nettype none

module tsp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tsp_pkg::div_cmd_t cmd,
    output tsp_pkg::div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(tsp_pkg::DIM_W + 1);

    logic [CNT_W-1:0]          cnt_reg;
    logic                      done_reg;
    logic [tsp_pkg::DIM_W-1:0] quo_reg;
    logic [tsp_pkg::N_W-1:0]   rem_reg;
    logic [tsp_pkg::N_W-1:0]   dvs_reg;

    logic [tsp_pkg::N_W:0]     trial;
    logic [tsp_pkg::N_W:0]     diff;
    logic                      fits;
    logic [tsp_pkg::N_W-1:0]   rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[tsp_pkg::DIM_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        // remainder stays below the divisor, so it fits N_W bits either way
        rem_next = fits ? diff[tsp_pkg::N_W-1:0] : trial[tsp_pkg::N_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !cmd.start && (cnt_reg == CNT_W'(1));
            if (cmd.start)
            begin
                cnt_reg <= CNT_W'(tsp_pkg::DIM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
            dvs_reg <= cmd.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[tsp_pkg::DIM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/tsp_seq.sv @@
// Sequencer: argument checks, grid setup, band walk and result register.
`default_nettype none

module tsp_seq #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_SHARDS    = 64,
    parameter int EW            = 9
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tsp_req_if.sink                           req,
    tsp_rsp_if.source                         rsp,
    input  wire logic [tsp_pkg::N_W-1:0]      shard_count,
    input  wire logic [tsp_pkg::MODE_W-1:0]   split_mode,
    input  wire logic [EW-1:0]                entries_used,
    output logic                              commit,
    output tsp_pkg::div_cmd_t                 div_cmd,
    input  wire tsp_pkg::div_rsp_t            div_rsp
);

    localparam int SW = ((EW > tsp_pkg::N_W) ? EW : tsp_pkg::N_W) + 1;
    localparam int DW = tsp_pkg::DIM_W;
    localparam int NW = tsp_pkg::N_W;

    tsp_pkg::tsp_state_t state_reg, state_next;

    logic [DW-1:0]              rows_reg, cols_reg;
    logic [NW-1:0]              n_reg;
    logic [tsp_pkg::MODE_W-1:0] mode_reg;
    logic [tsp_pkg::NR_W-1:0]   nr_reg;
    logic [NW-1:0]              cparts_reg;
    logic [DW-1:0]              rbase_reg, cbase_reg;
    logic [NW-1:0]              rrem_reg, crem_reg;
    logic [tsp_pkg::IDX_W-1:0]  rband_reg, cband_reg, shard_reg;
    logic [DW-1:0]              rstart_reg, cstart_reg;
    logic [DW-1:0]              rend_reg, cend_reg, rlen_reg, clen_reg;
    logic [tsp_pkg::STATUS_W-1:0] err_reg;

    logic                         out_valid_reg;
    logic [tsp_pkg::STATUS_W-1:0] out_status_reg;
    logic [tsp_pkg::IDX_W-1:0]    out_index_reg;
    logic [DW-1:0]                out_rs_reg, out_re_reg, out_cs_reg, out_ce_reg;
    logic [tsp_pkg::BYTES_W-1:0]  out_bytes_reg;
    logic                         out_last_reg;

    logic                 accept;
    logic                 bad_arg;
    logic                 table_full;
    logic                 is_block;
    logic [2*tsp_pkg::NR_W-1:0] nr_sq;
    logic                 nr_grow;
    logic [NW-1:0]        setup_parts;
    logic [NW-1:0]        col_parts;
    logic [NW-1:0]        nc_dividend;
    logic                 slot_free;
    logic                 load_ok;
    logic                 load_err;
    logic                 is_last;
    logic                 row_wrap;
    logic                 rband_extra, cband_extra;
    logic [2*DW-1:0]      area;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == tsp_pkg::ST_IDLE);

    assign bad_arg    = (req.row_count == '0) || (req.col_count == '0) ||
                        (shard_count == '0) || (shard_count > NW'(MAX_SHARDS));
    assign table_full = (SW'(entries_used) + SW'(shard_count)) > SW'(TABLE_ENTRIES);
    assign commit     = accept && !bad_arg && !table_full;

    assign is_block    = (mode_reg != tsp_pkg::MODE_ROWS) && (mode_reg != tsp_pkg::MODE_COLS);
    assign nr_sq       = nr_reg * nr_reg;
    assign nr_grow     = is_block && (nr_sq < (2*tsp_pkg::NR_W)'(n_reg));
    assign setup_parts = is_block ? NW'(nr_reg) :
                         ((mode_reg == tsp_pkg::MODE_ROWS) ? n_reg : NW'(1));
    assign col_parts   = (mode_reg == tsp_pkg::MODE_COLS) ? n_reg : NW'(1);
    // ceil(n / nr) as floor((n + nr - 1) / nr)
    assign nc_dividend = n_reg + NW'(nr_reg) - NW'(1);

    assign slot_free = !out_valid_reg || rsp.ready;
    assign load_ok   = (state_reg == tsp_pkg::ST_LOAD) && slot_free;
    assign load_err  = (state_reg == tsp_pkg::ST_ERR) && slot_free;
    assign is_last   = (NW'(shard_reg) + NW'(1)) == n_reg;
    assign row_wrap  = (NW'(cband_reg) + NW'(1)) == cparts_reg;

    assign rband_extra = NW'(rband_reg) < rrem_reg;
    assign cband_extra = NW'(cband_reg) < crem_reg;
    assign area        = rlen_reg * clen_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (bad_arg || table_full) ? tsp_pkg::ST_ERR : tsp_pkg::ST_SETUP;
                end
            end
            tsp_pkg::ST_ERR:
            begin
                if (slot_free)
                begin
                    state_next = tsp_pkg::ST_IDLE;
                end
            end
            tsp_pkg::ST_SETUP:
            begin
                if (!nr_grow)
                begin
                    state_next = tsp_pkg::ST_DIV_ROW;
                end
            end
            tsp_pkg::ST_DIV_ROW:
            begin
                if (div_rsp.done)
                begin
                    state_next = is_block ? tsp_pkg::ST_DIV_NC : tsp_pkg::ST_DIV_COL;
                end
            end
            tsp_pkg::ST_DIV_NC:
            begin
                if (div_rsp.done)
                begin
                    state_next = tsp_pkg::ST_DIV_COL;
                end
            end
            tsp_pkg::ST_DIV_COL:
            begin
                if (div_rsp.done)
                begin
                    state_next = tsp_pkg::ST_CALC;
                end
            end
            tsp_pkg::ST_CALC:
            begin
                state_next = tsp_pkg::ST_LOAD;
            end
            tsp_pkg::ST_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = is_last ? tsp_pkg::ST_IDLE : tsp_pkg::ST_CALC;
                end
            end
            default:
            begin
                state_next = tsp_pkg::ST_IDLE;
            end
        endcase
    end

    // divider commands
    always_comb
    begin
        div_cmd.start    = 1'b0;
        div_cmd.dividend = rows_reg;
        div_cmd.divisor  = setup_parts;
        unique case (state_reg)
            tsp_pkg::ST_SETUP:
            begin
                div_cmd.start = !nr_grow;
            end
            tsp_pkg::ST_DIV_ROW:
            begin
                div_cmd.start = div_rsp.done;
                if (is_block)
                begin
                    div_cmd.dividend = DW'(nc_dividend);
                    div_cmd.divisor  = NW'(nr_reg);
                end
                else
                begin
                    div_cmd.dividend = cols_reg;
                    div_cmd.divisor  = col_parts;
                end
            end
            tsp_pkg::ST_DIV_NC:
            begin
                div_cmd.start    = div_rsp.done;
                div_cmd.dividend = cols_reg;
                div_cmd.divisor  = div_rsp.quotient[NW-1:0];
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_ok || load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rows_reg <= req.row_count;
            cols_reg <= req.col_count;
            n_reg    <= shard_count;
            mode_reg <= split_mode;
            nr_reg   <= tsp_pkg::NR_W'(1);
            err_reg  <= bad_arg ? tsp_pkg::STATUS_INVALID : tsp_pkg::STATUS_FULL;
        end

        if ((state_reg == tsp_pkg::ST_SETUP) && nr_grow)
        begin
            nr_reg <= nr_reg + tsp_pkg::NR_W'(1);
        end

        if ((state_reg == tsp_pkg::ST_DIV_ROW) && div_rsp.done)
        begin
            rbase_reg <= div_rsp.quotient;
            rrem_reg  <= div_rsp.remainder;
            if (!is_block)
            begin
                cparts_reg <= col_parts;
            end
        end

        if ((state_reg == tsp_pkg::ST_DIV_NC) && div_rsp.done)
        begin
            cparts_reg <= div_rsp.quotient[NW-1:0];
        end

        if ((state_reg == tsp_pkg::ST_DIV_COL) && div_rsp.done)
        begin
            cbase_reg  <= div_rsp.quotient;
            crem_reg   <= div_rsp.remainder;
            rband_reg  <= '0;
            cband_reg  <= '0;
            shard_reg  <= '0;
            rstart_reg <= '0;
            cstart_reg <= '0;
        end

        if (state_reg == tsp_pkg::ST_CALC)
        begin
            rlen_reg <= rbase_reg + DW'(rband_extra);
            clen_reg <= cbase_reg + DW'(cband_extra);
            rend_reg <= rstart_reg + rbase_reg + DW'(rband_extra);
            cend_reg <= cstart_reg + cbase_reg + DW'(cband_extra);
        end

        if (load_ok)
        begin
            out_status_reg <= tsp_pkg::STATUS_OK;
            out_index_reg  <= shard_reg;
            out_rs_reg     <= rstart_reg;
            out_re_reg     <= rend_reg;
            out_cs_reg     <= cstart_reg;
            out_ce_reg     <= cend_reg;
            out_bytes_reg  <= {area, 2'b00};
            out_last_reg   <= is_last;
            // advance across the grid, wrapping to the next row band
            shard_reg <= shard_reg + tsp_pkg::IDX_W'(1);
            if (row_wrap)
            begin
                cband_reg  <= '0;
                cstart_reg <= '0;
                rband_reg  <= rband_reg + tsp_pkg::IDX_W'(1);
                rstart_reg <= rend_reg;
            end
            else
            begin
                cband_reg  <= cband_reg + tsp_pkg::IDX_W'(1);
                cstart_reg <= cend_reg;
            end
        end
        else if (load_err)
        begin
            out_status_reg <= err_reg;
            out_index_reg  <= '0;
            out_rs_reg     <= '0;
            out_re_reg     <= '0;
            out_cs_reg     <= '0;
            out_ce_reg     <= '0;
            out_bytes_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.shard_index = out_index_reg;
    assign rsp.row_start   = out_rs_reg;
    assign rsp.row_end     = out_re_reg;
    assign rsp.col_start   = out_cs_reg;
    assign rsp.col_end     = out_ce_reg;
    assign rsp.byte_size   = out_bytes_reg;
    assign rsp.last_shard  = out_last_reg;

endmodule

`default_nettype wire

@@ design/tensor_shard_partitioner.sv @@
// Top level of the tensor shard partitioner.
`default_nettype none

// Splits each matrix shape (row_count x col_count) into shard_count shards
// by rows, by columns or over a near-square grid, and returns one result per
// shard in shard order with last_shard on the final one; a bad argument or a
// full shard table gives one error result instead. The row and column band
// sizes (and the grid column count) each come from one pass of the shared
// bit-serial divider, the grid row count is found one candidate per cycle,
// and each shard then has its bounds formed in the calc state and its size
// multiplied into the result register in the load state, which waits for a
// free output slot. The request channel is ready only between shapes; the
// last result may still wait in the output register while the next shape
// starts. Register writes are taken every cycle and must only happen between
// shapes.
module tensor_shard_partitioner #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_SHARDS    = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tsp_req_if.sink   req,
    tsp_rsp_if.source rsp,
    tsp_cfg_if.sink   cfg
);

    localparam int EW = $clog2(TABLE_ENTRIES + 1);

    logic [tsp_pkg::N_W-1:0]    shard_count_reg;
    logic [tsp_pkg::MODE_W-1:0] split_mode_reg;
    logic [EW-1:0]              entries_reg;
    logic                       commit;
    tsp_pkg::div_cmd_t          div_cmd;
    tsp_pkg::div_rsp_t          div_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shard_count_reg <= tsp_pkg::N_W'(1);
            split_mode_reg  <= tsp_pkg::MODE_ROWS;
            entries_reg     <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    tsp_pkg::CFG_SHARD_COUNT:
                    begin
                        shard_count_reg <= cfg.data[tsp_pkg::N_W-1:0];
                    end
                    tsp_pkg::CFG_SPLIT_MODE:
                    begin
                        split_mode_reg <= cfg.data[tsp_pkg::MODE_W-1:0];
                    end
                    default:
                    begin
                        // drop writes to unknown registers
                    end
                endcase
            end
            if (commit)
            begin
                entries_reg <= entries_reg + EW'(shard_count_reg);
            end
        end
    end

    tsp_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_SHARDS    (MAX_SHARDS),
        .EW            (EW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .shard_count  (shard_count_reg),
        .split_mode   (split_mode_reg),
        .entries_used (entries_reg),
        .commit       (commit),
        .div_cmd      (div_cmd),
        .div_rsp      (div_rsp)
    );

    tsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the tensor shard partitioner: shard prediction under random flow control.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH = 256;
    localparam int SHARD_LIMIT = 64;

    localparam logic [tsp_pkg::MODE_W-1:0]    MODE_GRID      = 2'd2;
    localparam logic [tsp_pkg::MODE_W-1:0]    MODE_GRID_ALT  = 2'd3;
    localparam logic [tsp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'hF;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG
    } stall_style_t;

    typedef struct packed {
        logic [tsp_pkg::STATUS_W-1:0] status;
        logic [tsp_pkg::IDX_W-1:0]    shard_index;
        logic [tsp_pkg::DIM_W-1:0]    row_start;
        logic [tsp_pkg::DIM_W-1:0]    row_end;
        logic [tsp_pkg::DIM_W-1:0]    col_start;
        logic [tsp_pkg::DIM_W-1:0]    col_end;
        logic [tsp_pkg::BYTES_W-1:0]  byte_size;
        logic                         last_shard;
    } shard_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tsp_req_if shape_if();
    tsp_rsp_if shard_if();
    tsp_cfg_if reg_if();

    tensor_shard_partitioner #(
        .TABLE_ENTRIES(TABLE_DEPTH),
        .MAX_SHARDS   (SHARD_LIMIT)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (shape_if),
        .rsp  (shard_if),
        .cfg  (reg_if)
    );

    always #5 clk = ~clk;

    // Mirror of the block's registers and table occupancy
    logic [tsp_pkg::N_W-1:0]    cur_shards;
    logic [tsp_pkg::MODE_W-1:0] cur_mode;
    int unsigned                table_used;

    shard_result_t shard_expect_q[$];

    int unsigned failures;
    int unsigned shapes_sent;
    int unsigned burst_left;
    int unsigned ok_seen;
    int unsigned invalid_seen;
    int unsigned full_seen;

    // Balanced split: the first (len mod parts) bands get one extra line.
    function automatic void split_band(input int unsigned len, input int unsigned parts,
                                       input int unsigned b, output int unsigned lo,
                                       output int unsigned hi);
        int unsigned base;
        int unsigned rem;
        base = len / parts;
        rem  = len % parts;
        lo   = b * base + ((b < rem) ? b : rem);
        hi   = lo + base + ((b < rem) ? 1 : 0);
    endfunction

    function automatic void predict_shards(input logic [tsp_pkg::DIM_W-1:0] rows,
                                           input logic [tsp_pkg::DIM_W-1:0] cols);
        shard_result_t res;
        int unsigned n;
        int unsigned nr;
        int unsigned nc;
        int unsigned s;
        int unsigned rs;
        int unsigned re;
        int unsigned cs;
        int unsigned ce;
        n = 32'(cur_shards);
        res = '0;
        res.last_shard = 1'b1;
        if (rows == '0 || cols == '0 || n == 0 || n > SHARD_LIMIT)
        begin
            res.status = tsp_pkg::STATUS_INVALID;
            shard_expect_q.push_back(res);
            return;
        end
        if (table_used + n > TABLE_DEPTH)
        begin
            res.status = tsp_pkg::STATUS_FULL;
            shard_expect_q.push_back(res);
            return;
        end
        nr = 1;
        nc = 1;
        if (cur_mode != tsp_pkg::MODE_ROWS && cur_mode != tsp_pkg::MODE_COLS)
        begin
            while (nr * nr < n)
                nr++;
            nc = (n + nr - 1) / nr;
        end
        for (s = 0; s < n; s++)
        begin
            rs = 0;
            re = 32'(rows);
            cs = 0;
            ce = 32'(cols);
            if (cur_mode == tsp_pkg::MODE_ROWS)
                split_band(32'(rows), n, s, rs, re);
            else if (cur_mode == tsp_pkg::MODE_COLS)
                split_band(32'(cols), n, s, cs, ce);
            else
            begin
                split_band(32'(rows), nr, s / nc, rs, re);
                split_band(32'(cols), nc, s % nc, cs, ce);
            end
            res.status      = tsp_pkg::STATUS_OK;
            res.shard_index = tsp_pkg::IDX_W'(s);
            res.row_start   = tsp_pkg::DIM_W'(rs);
            res.row_end     = tsp_pkg::DIM_W'(re);
            res.col_start   = tsp_pkg::DIM_W'(cs);
            res.col_end     = tsp_pkg::DIM_W'(ce);
            res.byte_size   = tsp_pkg::BYTES_W'(64'(re - rs) * 64'(ce - cs) * 64'd4);
            res.last_shard  = (s + 1 == n);
            shard_expect_q.push_back(res);
        end
        table_used += n;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_shape(input logic [tsp_pkg::DIM_W-1:0] rows,
                              input logic [tsp_pkg::DIM_W-1:0] cols);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                shape_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        shape_if.valid     <= 1'b1;
        shape_if.row_count <= rows;
        shape_if.col_count <= cols;
        do
            @(posedge clk);
        while (!shape_if.ready);
        predict_shards(rows, cols);
        shapes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Hold the request side idle until every expected shard has come back.
    task automatic drain();
        shape_if.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (shard_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [tsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsp_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        do
            @(posedge clk);
        while (!reg_if.ready);
        if (idx == tsp_pkg::CFG_SHARD_COUNT)
            cur_shards = val[tsp_pkg::N_W-1:0];
        else if (idx == tsp_pkg::CFG_SPLIT_MODE)
            cur_mode = val[tsp_pkg::MODE_W-1:0];
        @(negedge clk);
        reg_if.valid <= 1'b0;
    endtask

    task automatic set_split(input logic [tsp_pkg::CFG_DATA_W-1:0] count_data,
                             input logic [tsp_pkg::CFG_DATA_W-1:0] mode_data);
        drain();
        write_reg(tsp_pkg::CFG_SHARD_COUNT, count_data);
        write_reg(tsp_pkg::CFG_SPLIT_MODE, mode_data);
    endtask

    task automatic test_reset_defaults();
        send_shape(24'd1, 24'd1);
        send_shape('1, '1);
        send_shape(24'h800000, 24'd1);
    endtask

    task automatic test_bad_arguments();
        send_shape('0, 24'h00ABCD);
        send_shape('1, '0);
        send_shape('0, '0);
        set_split(8'd0, tsp_pkg::MODE_ROWS);
        send_shape(24'd3, 24'd3);
        set_split(tsp_pkg::CFG_DATA_W'(SHARD_LIMIT + 1), tsp_pkg::MODE_ROWS);
        send_shape(24'd3, 24'd3);
        set_split(8'h7F, tsp_pkg::MODE_COLS);
        send_shape(24'd3, 24'd3);
        // A write to an unknown index must leave both registers alone
        set_split(8'd2, tsp_pkg::MODE_ROWS);
        write_reg(CFG_UNUSED_IDX, '0);
        send_shape(24'd9, 24'd4);
    endtask

    task automatic test_row_split();
        // More shards than rows: most bands come out empty
        set_split(tsp_pkg::CFG_DATA_W'(SHARD_LIMIT), tsp_pkg::MODE_ROWS);
        send_shape(24'd10, '1);
        set_split(8'd7, tsp_pkg::MODE_ROWS);
        send_shape(24'd100, 24'd3);
    endtask

    task automatic test_col_split();
        set_split(8'd7, tsp_pkg::MODE_COLS);
        send_shape(24'd5, 24'd23);
        set_split(8'd3, tsp_pkg::MODE_COLS);
        send_shape('1, 24'd2);
    endtask

    task automatic test_grid_split();
        // Bit 7 of the count is dropped: five shards on a 3x2 grid, one cell unused
        set_split(8'h85, MODE_GRID);
        send_shape(24'd17, 24'd9);
        set_split(8'd12, MODE_GRID);
        send_shape(24'd1000, 24'd1001);
        // Mode three behaves as the grid
        set_split(8'd10, 8'hFF);
        send_shape(24'd30, 24'd30);
        set_split(8'd3, MODE_GRID_ALT);
        send_shape(24'd1, 24'd1);
        set_split(8'd2, MODE_GRID);
        send_shape('1, '1);
    endtask

    task automatic test_random_shapes();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned pick;
        int unsigned k;
        logic [tsp_pkg::CFG_DATA_W-1:0] count_data;
        logic [tsp_pkg::DIM_W-1:0] rows;
        logic [tsp_pkg::DIM_W-1:0] cols;
        sent = 0;
        while (sent < 190)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                count_data = tsp_pkg::CFG_DATA_W'($urandom_range(1, 4));
            else if (pick < 8)
                count_data = tsp_pkg::CFG_DATA_W'($urandom_range(5, SHARD_LIMIT));
            else if (pick == 8)
                count_data = tsp_pkg::CFG_DATA_W'($urandom);
            else
                count_data = '0;
            set_split(count_data, tsp_pkg::CFG_DATA_W'($urandom));
            phase_len = (count_data[tsp_pkg::N_W-1:0] > 8) ? $urandom_range(1, 2)
                                                           : $urandom_range(4, 16);
            for (k = 0; k < phase_len; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                begin
                    rows = tsp_pkg::DIM_W'($urandom);
                    cols = tsp_pkg::DIM_W'($urandom);
                end
                else if (pick < 16)
                begin
                    rows = tsp_pkg::DIM_W'($urandom_range(1, 64));
                    cols = tsp_pkg::DIM_W'($urandom_range(1, 64));
                end
                else if (pick < 18)
                begin
                    rows = (pick == 16) ? '0 : tsp_pkg::DIM_W'($urandom_range(1, 999));
                    cols = (pick == 17) ? '0 : tsp_pkg::DIM_W'($urandom_range(1, 999));
                end
                else
                begin
                    rows = $urandom_range(0, 1) ? '1 : tsp_pkg::DIM_W'(1);
                    cols = $urandom_range(0, 1) ? '1 : tsp_pkg::DIM_W'(1);
                end
                send_shape(rows, cols);
            end
            sent += phase_len;
        end
    endtask

    task automatic test_table_limit();
        int unsigned room;
        int unsigned n;
        room = TABLE_DEPTH - table_used;
        // Fill the table exactly, then push one shard past it
        while (room > 0)
        begin
            n = (room > SHARD_LIMIT) ? SHARD_LIMIT : room;
            set_split(tsp_pkg::CFG_DATA_W'(n), tsp_pkg::MODE_ROWS);
            send_shape(tsp_pkg::DIM_W'($urandom_range(1, 24'hFFFFFF)),
                       tsp_pkg::DIM_W'($urandom_range(1, 24'hFFFFFF)));
            room -= n;
        end
        set_split(8'd1, tsp_pkg::MODE_COLS);
        send_shape(24'd3, 24'd4);
        // Argument errors take precedence over a full table
        send_shape('0, 24'd4);
        set_split(8'd0, MODE_GRID);
        send_shape(24'd3, 24'd4);
    endtask

    // Receiver: switch between no stalls, random stalls and long stalls
    initial
    begin
        stall_style_t style;
        int unsigned style_left;
        int unsigned hold;
        shard_if.ready = 1'b0;
        style = STALL_NONE;
        style_left = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (style_left == 0)
            begin
                style = stall_style_t'($urandom_range(0, 2));
                style_left = $urandom_range(16, 160);
            end
            style_left--;
            case (style)
                STALL_NONE:
                    shard_if.ready <= 1'b1;
                STALL_RANDOM:
                    shard_if.ready <= ($urandom_range(0, 9) > 2);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        shard_if.ready <= 1'b0;
                    end
                    else
                    begin
                        shard_if.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            hold = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : check_shards
        shard_result_t got;
        shard_result_t want;
        if (rst_n && shard_if.valid && shard_if.ready)
        begin
            got.status      = shard_if.status;
            got.shard_index = shard_if.shard_index;
            got.row_start   = shard_if.row_start;
            got.row_end     = shard_if.row_end;
            got.col_start   = shard_if.col_start;
            got.col_end     = shard_if.col_end;
            got.byte_size   = shard_if.byte_size;
            got.last_shard  = shard_if.last_shard;
            if (shard_expect_q.size() == 0)
            begin
                $error("unexpected shard result: status %0d shard_index %0d",
                       got.status, got.shard_index);
                failures++;
            end
            else
            begin
                want = shard_expect_q.pop_front();
                case (want.status)
                    tsp_pkg::STATUS_OK:      ok_seen++;
                    tsp_pkg::STATUS_INVALID: invalid_seen++;
                    default:                 full_seen++;
                endcase
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.shard_index !== want.shard_index)
                begin
                    $error("shard_index: expected %0d, got %0d",
                           want.shard_index, got.shard_index);
                    failures++;
                end
                if (got.row_start !== want.row_start)
                begin
                    $error("row_start: expected %0d, got %0d", want.row_start, got.row_start);
                    failures++;
                end
                if (got.row_end !== want.row_end)
                begin
                    $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
                    failures++;
                end
                if (got.col_start !== want.col_start)
                begin
                    $error("col_start: expected %0d, got %0d", want.col_start, got.col_start);
                    failures++;
                end
                if (got.col_end !== want.col_end)
                begin
                    $error("col_end: expected %0d, got %0d", want.col_end, got.col_end);
                    failures++;
                end
                if (got.byte_size !== want.byte_size)
                begin
                    $error("byte_size: expected %0d, got %0d", want.byte_size, got.byte_size);
                    failures++;
                end
                if (got.last_shard !== want.last_shard)
                begin
                    $error("last_shard: expected %0d, got %0d",
                           want.last_shard, got.last_shard);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d shard results outstanding", shard_expect_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        shape_if.valid     = 1'b0;
        shape_if.row_count = '0;
        shape_if.col_count = '0;
        reg_if.valid       = 1'b0;
        reg_if.index       = '0;
        reg_if.data        = '0;
        rst_n              = 1'b0;
        cur_shards         = tsp_pkg::N_W'(1);
        cur_mode           = tsp_pkg::MODE_ROWS;
        table_used         = 0;
        failures           = 0;
        shapes_sent        = 0;
        burst_left         = 0;
        ok_seen            = 0;
        invalid_seen       = 0;
        full_seen          = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_bad_arguments();
        test_row_split();
        test_col_split();
        test_grid_split();
        test_random_shapes();
        test_table_limit();
        drain();

        // Catch any stray result after the last expected one
        repeat (300) @(posedge clk);
        $display("Sent %0d matrix shapes over row, column and grid splits; table ended at %0d",
                 shapes_sent, table_used);
        $display("Checked %0d shard results, %0d invalid-argument and %0d table-full errors",
                 ok_seen, invalid_seen, full_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
